>>> rtl/msd_pkg.sv
// Shared types and constants of the motion swipe detector.
package msd_pkg;

   // Configuration register indexes
   localparam logic [2:0] CSR_FRAME_WIDTH        = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT       = 3'd1;
   localparam logic [2:0] CSR_NOISE_FLOOR        = 3'd2;
   localparam logic [2:0] CSR_ACTIVITY_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_SWIPE_RUN_LENGTH   = 3'd4;

   // Register reset values
   localparam logic [10:0] RST_FRAME_WIDTH        = 11'd640;
   localparam logic [9:0]  RST_FRAME_HEIGHT       = 10'd480;
   localparam logic [7:0]  RST_NOISE_FLOOR        = 8'd10;
   localparam logic [7:0]  RST_ACTIVITY_THRESHOLD = 8'd20;
   localparam logic [7:0]  RST_SWIPE_RUN_LENGTH   = 8'd4;

   // Direction of the last move of the motion centre
   localparam logic [1:0] DIR_NONE   = 2'd0;
   localparam logic [1:0] DIR_HIGHER = 2'd1;
   localparam logic [1:0] DIR_LOWER  = 2'd2;

   localparam logic [7:0] RUN_MAX = 8'd255;
   localparam logic [7:0] LEVEL_MAX = 8'd255;

   typedef struct packed {
      logic [7:0] noise_floor;
      logic [7:0] activity_threshold;
      logic [7:0] swipe_run_length;
   } msd_cfg_type;

endpackage

>>> rtl/msd_ram.sv
// Generic simple dual-port RAM with registered read.
module msd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/msd_front.sv
// Pixel front end: position tracking, frame differencing and column sums.
module msd_front
   import msd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [7:0]                          req_pixel,
   input  logic                                req_frame_start,
   output logic                                q_push,
   output logic                                q_last,
   output logic [$clog2(255*MAX_HEIGHT+1)-1:0] q_sum,
   input  logic                                q_full
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int RH = $clog2(MAX_HEIGHT+1);
   localparam int SW = $clog2(255*MAX_HEIGHT+1);
   localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);

   localparam logic [2:0] F_IDLE  = 3'd0;
   localparam logic [2:0] F_CLR   = 3'd1;
   localparam logic [2:0] F_RD    = 3'd2;
   localparam logic [2:0] F_WR    = 3'd3;
   localparam logic [2:0] F_WRD   = 3'd4;
   localparam logic [2:0] F_WPUSH = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] pos_col_ff, pos_col_in;
   logic [RH-1:0] pos_row_ff, pos_row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RH-1:0] row_ff, row_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [7:0]    pix_ff, pix_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic          clean_ff, clean_in;

   logic [CW-1:0] c0, c1;
   logic [RH-1:0] r0, r1;
   logic          accept;
   logic [7:0]    old_pix, diff;
   logic [SW-1:0] old_sum, new_sum;
   logic          walk_in_range;

   logic          sum_rd_en, sum_wr_en;
   logic [CW-1:0] sum_rd_addr, sum_wr_addr;
   logic [SW-1:0] sum_wr_data;

   assign req_full = state_ff != F_IDLE;
   assign accept   = req_push && !req_full;

   // Resolve where the incoming pixel lands
   always_comb begin
      c0 = req_frame_start ? '0 : pos_col_ff;
      r0 = req_frame_start ? '0 : pos_row_ff;
      c1 = c0;
      r1 = r0;
      if (WW'(c0) >= width) begin
         c1 = '0;
         r1 = r0 + 1'b1;
      end
      if (r1 >= height) begin
         c1 = '0;
         r1 = '0;
      end
   end

   assign diff          = (pix_ff > old_pix) ? pix_ff - old_pix : old_pix - pix_ff;
   assign new_sum       = old_sum + SW'(diff);
   assign walk_in_range = WW'(walk_ff) < width;

   always_comb begin
      state_in   = state_ff;
      pos_col_in = pos_col_ff;
      pos_row_in = pos_row_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      addr_in    = addr_ff;
      pix_in     = pix_ff;
      walk_in    = walk_ff;
      clean_in   = clean_ff;
      q_push     = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               col_in  = c1;
               row_in  = r1;
               pix_in  = req_pixel;
               addr_in = AW'(32'(r1) * MAX_WIDTH + 32'(c1));
               walk_in = '0;
               // a frame begins on stale sums: sweep them first
               if (c1 == '0 && r1 == '0 && !clean_ff) begin
                  state_in = F_CLR;
               end else begin
                  state_in = F_RD;
               end
            end
         end
         F_CLR: begin
            if (walk_ff == CW'(MAX_WIDTH-1)) begin
               clean_in = 1'b1;
               state_in = F_RD;
            end else begin
               walk_in = walk_ff + 1'b1;
            end
         end
         F_RD: begin
            state_in = F_WR;
         end
         F_WR: begin
            clean_in = 1'b0;
            state_in = F_IDLE;
            if (WW'(col_ff) + 1'b1 < width) begin
               pos_col_in = col_ff + 1'b1;
            end else begin
               pos_col_in = '0;
               if (row_ff + 1'b1 < height) begin
                  pos_row_in = row_ff + 1'b1;
               end else begin
                  pos_row_in = '0;
                  walk_in    = '0;
                  state_in   = F_WRD;
               end
            end
         end
         F_WRD: begin
            state_in = F_WPUSH;
         end
         F_WPUSH: begin
            if (!walk_in_range || !q_full) begin
               q_push = walk_in_range;
               if (walk_ff == CW'(MAX_WIDTH-1)) begin
                  clean_in = 1'b1;
                  state_in = F_IDLE;
               end else begin
                  walk_in  = walk_ff + 1'b1;
                  state_in = F_WRD;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   assign q_last = WW'(walk_ff) + 1'b1 == width;
   assign q_sum  = old_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_IDLE;
         pos_col_ff <= '0;
         pos_row_ff <= '0;
         clean_ff   <= 1'b0;
         walk_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         pos_col_ff <= pos_col_in;
         pos_row_ff <= pos_row_in;
         clean_ff   <= clean_in;
         walk_ff    <= walk_in;
      end
      col_ff  <= col_in;
      row_ff  <= row_in;
      addr_ff <= addr_in;
      pix_ff  <= pix_in;
   end

   msd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH*MAX_HEIGHT)) u_prev_ram (
      .clock  (clock),
      .wr_en  (state_ff == F_WR),
      .wr_addr(addr_ff),
      .wr_data(pix_ff),
      .rd_en  (state_ff == F_RD),
      .rd_addr(addr_ff),
      .rd_data(old_pix)
   );

   // Drain walk reads each column and zeroes it behind itself
   assign sum_rd_en   = (state_ff == F_RD) || (state_ff == F_WRD);
   assign sum_rd_addr = (state_ff == F_RD) ? col_ff : walk_ff;
   assign sum_wr_en   = (state_ff == F_WR) || (state_ff == F_CLR) || (state_ff == F_WRD);
   assign sum_wr_addr = (state_ff == F_WR) ? col_ff : walk_ff;
   assign sum_wr_data = (state_ff == F_WR) ? new_sum : '0;

   msd_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_sum_ram (
      .clock  (clock),
      .wr_en  (sum_wr_en),
      .wr_addr(sum_wr_addr),
      .wr_data(sum_wr_data),
      .rd_en  (sum_rd_en),
      .rd_addr(sum_rd_addr),
      .rd_data(old_sum)
   );

endmodule

>>> rtl/msd_queue.sv
// Short queue of column sums between the front end and the analyser.
module msd_queue #(
   parameter int WIDTH = 18
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             valid
);

   logic [WIDTH-1:0] slot_ff [4];
   logic [1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [2:0]       count_ff;
   logic             do_push, do_pop;

   assign full     = count_ff == 3'd4;
   assign valid    = count_ff != 3'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + {2'b0, do_push} - {2'b0, do_pop};
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/msd_back.sv
// Frame analyser: column levels, peak, motion centre and swipe run.
module msd_back
   import msd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  msd_cfg_type                         cfg,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height,
   input  logic                                q_valid,
   input  logic                                q_last,
   input  logic [$clog2(255*MAX_HEIGHT+1)-1:0] q_sum,
   output logic                                q_pop,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_swipe,
   output logic                                rsp_swipe_toward_higher,
   output logic [10:0]                         rsp_center_column,
   output logic [7:0]                          rsp_peak_level,
   output logic                                rsp_motion_active,
   output logic                                rsp_reference_only
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RH = $clog2(MAX_HEIGHT+1);
   localparam int DW = RH + 8;
   localparam int TW = $clog2(255*MAX_WIDTH+1);

   localparam logic [2:0] B_WAIT  = 3'd0;
   localparam logic [2:0] B_DIV   = 3'd1;
   localparam logic [2:0] B_ROUND = 3'd2;
   localparam logic [2:0] B_SRD   = 3'd3;
   localparam logic [2:0] B_SCHK  = 3'd4;
   localparam logic [2:0] B_OUT   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [7:0]    quo_ff, quo_in;
   logic [2:0]    step_ff, step_in;
   logic          sat_ff, sat_in;
   logic          last_ff, last_in;
   logic [CW-1:0] col_ff, col_in;
   logic [TW-1:0] total_ff, total_in;
   logic [7:0]    peak_ff, peak_in;
   logic          active_ff, active_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [TW-1:0] cum_ff, cum_in;
   logic [CW-1:0] center_ff, center_in;
   logic          have_prev_ff, have_prev_in;
   logic [CW-1:0] last_center_ff, last_center_in;
   logic [1:0]    last_dir_ff, last_dir_in;
   logic [7:0]    run_ff, run_in;

   logic          out_valid_ff, out_valid_in;
   logic          o_swipe_ff, o_swipe_in, o_higher_ff, o_higher_in;
   logic [10:0]   o_center_ff, o_center_in;
   logic [7:0]    o_peak_ff, o_peak_in;
   logic          o_active_ff, o_active_in, o_ref_ff, o_ref_in;

   logic [DW-1:0] div_cmp;
   logic [RH:0]   two_r, h_ext;
   logic [8:0]    q9;
   logic [7:0]    q_sat, level;
   logic [TW-1:0] total_new, cum_new;
   logic [7:0]    peak_new;
   logic [7:0]    lvl_rd;
   logic          higher;
   logic [1:0]    dir;
   logic [7:0]    run_new;

   assign div_cmp = DW'(height) << step_ff;

   // Round half to even, saturate, remove the noise floor
   always_comb begin
      two_r = {rem_ff[RH-1:0], 1'b0};
      h_ext = {1'b0, height};
      q9    = {1'b0, quo_ff};
      if (two_r > h_ext || (two_r == h_ext && quo_ff[0])) begin
         q9 = q9 + 1'b1;
      end
      q_sat = (sat_ff || q9[8]) ? LEVEL_MAX : q9[7:0];
      level = (q_sat > cfg.noise_floor) ? q_sat - cfg.noise_floor : 8'd0;
   end

   assign total_new = total_ff + TW'(level);
   assign peak_new  = (level > peak_ff) ? level : peak_ff;
   assign cum_new   = cum_ff + TW'(lvl_rd);

   always_comb begin
      higher  = last_center_ff < center_ff;
      dir     = higher ? DIR_HIGHER : DIR_LOWER;
      run_new = 8'd0;
      if (dir == last_dir_ff) begin
         run_new = (run_ff < RUN_MAX) ? run_ff + 1'b1 : run_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      sat_in         = sat_ff;
      last_in        = last_ff;
      col_in         = col_ff;
      total_in       = total_ff;
      peak_in        = peak_ff;
      active_in      = active_ff;
      idx_in         = idx_ff;
      cum_in         = cum_ff;
      center_in      = center_ff;
      have_prev_in   = have_prev_ff;
      last_center_in = last_center_ff;
      last_dir_in    = last_dir_ff;
      run_in         = run_ff;
      out_valid_in   = out_valid_ff;
      o_swipe_in     = o_swipe_ff;
      o_higher_in    = o_higher_ff;
      o_center_in    = o_center_ff;
      o_peak_in      = o_peak_ff;
      o_active_in    = o_active_ff;
      o_ref_in       = o_ref_ff;
      q_pop          = 1'b0;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         B_WAIT: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!have_prev_ff) begin
                  // reference frame: drop the sums
                  if (q_last) begin
                     state_in = B_OUT;
                  end
               end else begin
                  rem_in   = DW'(q_sum);
                  sat_in   = DW'(q_sum) >= (DW'(height) << 8);
                  quo_in   = '0;
                  step_in  = 3'd7;
                  last_in  = q_last;
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            if (rem_ff >= div_cmp) begin
               rem_in          = rem_ff - div_cmp;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == 3'd0) begin
               state_in = B_ROUND;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         B_ROUND: begin
            total_in = total_new;
            peak_in  = peak_new;
            col_in   = col_ff + 1'b1;
            if (last_ff) begin
               active_in = peak_new > cfg.activity_threshold;
               center_in = '0;
               idx_in    = '0;
               cum_in    = '0;
               state_in  = (peak_new > cfg.activity_threshold) ? B_SRD : B_OUT;
            end else begin
               state_in = B_WAIT;
            end
         end
         B_SRD: begin
            state_in = B_SCHK;
         end
         B_SCHK: begin
            if (cum_new >= (total_ff >> 1)) begin
               center_in = idx_ff;
               state_in  = B_OUT;
            end else begin
               cum_in   = cum_new;
               idx_in   = idx_ff + 1'b1;
               state_in = B_SRD;
            end
         end
         B_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               o_swipe_in   = 1'b0;
               o_higher_in  = 1'b0;
               o_center_in  = '0;
               o_peak_in    = '0;
               o_active_in  = 1'b0;
               o_ref_in     = 1'b0;
               if (!have_prev_ff) begin
                  o_ref_in     = 1'b1;
                  have_prev_in = 1'b1;
                  run_in       = '0;
               end else if (active_ff) begin
                  o_higher_in    = higher;
                  o_center_in    = 11'(center_ff);
                  o_peak_in      = peak_ff;
                  o_active_in    = 1'b1;
                  o_swipe_in     = run_new == cfg.swipe_run_length;
                  run_in         = run_new;
                  last_center_in = center_ff;
                  if (dir != last_dir_ff) begin
                     last_dir_in = dir;
                  end
               end else begin
                  o_peak_in      = peak_ff;
                  run_in         = '0;
                  last_center_in = '0;
               end
               col_in   = '0;
               total_in = '0;
               peak_in  = '0;
               state_in = B_WAIT;
            end
         end
         default: begin
            state_in = B_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_WAIT;
         col_ff         <= '0;
         total_ff       <= '0;
         peak_ff        <= '0;
         have_prev_ff   <= 1'b0;
         last_center_ff <= '0;
         last_dir_ff    <= DIR_NONE;
         run_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         total_ff       <= total_in;
         peak_ff        <= peak_in;
         have_prev_ff   <= have_prev_in;
         last_center_ff <= last_center_in;
         last_dir_ff    <= last_dir_in;
         run_ff         <= run_in;
         out_valid_ff   <= out_valid_in;
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      sat_ff      <= sat_in;
      last_ff     <= last_in;
      active_ff   <= active_in;
      idx_ff      <= idx_in;
      cum_ff      <= cum_in;
      center_ff   <= center_in;
      o_swipe_ff  <= o_swipe_in;
      o_higher_ff <= o_higher_in;
      o_center_ff <= o_center_in;
      o_peak_ff   <= o_peak_in;
      o_active_ff <= o_active_in;
      o_ref_ff    <= o_ref_in;
   end

   msd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_level_ram (
      .clock  (clock),
      .wr_en  (state_ff == B_ROUND),
      .wr_addr(col_ff),
      .wr_data(level),
      .rd_en  (state_ff == B_SRD),
      .rd_addr(idx_ff),
      .rd_data(lvl_rd)
   );

   assign rsp_empty               = !out_valid_ff;
   assign rsp_swipe               = o_swipe_ff;
   assign rsp_swipe_toward_higher = o_higher_ff;
   assign rsp_center_column       = o_center_ff;
   assign rsp_peak_level          = o_peak_ff;
   assign rsp_motion_active       = o_active_ff;
   assign rsp_reference_only      = o_ref_ff;

endmodule

>>> rtl/motion_swipe_detector.sv
// Top level of the motion swipe detector.
//
// Pixels enter in raster order on the req_ queue port (push/full); a pixel
// is taken when push is high and full is low. Each pixel passes through
// accept, read of the stored previous pixel and column sum, write back.
// On the last pixel of a frame the column sums are drained, over all
// MAX_WIDTH columns, into a 4-entry queue; the analyser runs each column
// through the rounding divider, then, on an active frame, runs the
// centre search column by column. Pixels of the next frame are
// accepted while the analyser works. One result per completed frame
// appears on the rsp_ port (empty/pop) and is held until popped; a stalled
// receiver back-pressures the analyser and then the column drain.
// After reset, and after a frame abandoned by an early frame_start, the
// first pixel of a frame waits while the column sums are swept to zero.
// Reset restores the register defaults and marks the next frame as
// reference only. csr_ writes are always ready.
module motion_swipe_detector
   import msd_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_swipe,
   output logic        rsp_swipe_toward_higher,
   output logic [10:0] rsp_center_column,
   output logic [7:0]  rsp_peak_level,
   output logic        rsp_motion_active,
   output logic        rsp_reference_only,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int RH = $clog2(MAX_HEIGHT+1);
   localparam int SW = $clog2(255*MAX_HEIGHT+1);

   logic [10:0]   frame_width_ff;
   logic [9:0]    frame_height_ff;
   msd_cfg_type   cfg_ff;
   logic [WW-1:0] width;
   logic [RH-1:0] height;

   logic          q_push, q_last, q_full, q_pop, q_valid;
   logic [SW-1:0] q_sum;
   logic [SW:0]   q_pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff            <= RST_FRAME_WIDTH;
         frame_height_ff           <= RST_FRAME_HEIGHT;
         cfg_ff.noise_floor        <= RST_NOISE_FLOOR;
         cfg_ff.activity_threshold <= RST_ACTIVITY_THRESHOLD;
         cfg_ff.swipe_run_length   <= RST_SWIPE_RUN_LENGTH;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:        frame_width_ff            <= csr_wdata;
            CSR_FRAME_HEIGHT:       frame_height_ff           <= csr_wdata[9:0];
            CSR_NOISE_FLOOR:        cfg_ff.noise_floor        <= csr_wdata[7:0];
            CSR_ACTIVITY_THRESHOLD: cfg_ff.activity_threshold <= csr_wdata[7:0];
            CSR_SWIPE_RUN_LENGTH:   cfg_ff.swipe_run_length   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Clamp the geometry to one and to the built maximum
   always_comb begin
      if (frame_width_ff == '0) begin
         width = WW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         width = WW'(MAX_WIDTH);
      end else begin
         width = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height = RH'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         height = RH'(MAX_HEIGHT);
      end else begin
         height = RH'(frame_height_ff);
      end
   end

   msd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock          (clock),
      .reset          (reset),
      .width          (width),
      .height         (height),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel      (req_pixel),
      .req_frame_start(req_frame_start),
      .q_push         (q_push),
      .q_last         (q_last),
      .q_sum          (q_sum),
      .q_full         (q_full)
   );

   msd_queue #(.WIDTH(SW+1)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({q_last, q_sum}),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .valid    (q_valid)
   );

   msd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg_ff),
      .height                 (height),
      .q_valid                (q_valid),
      .q_last                 (q_pop_data[SW]),
      .q_sum                  (q_pop_data[SW-1:0]),
      .q_pop                  (q_pop),
      .rsp_empty              (rsp_empty),
      .rsp_pop                (rsp_pop),
      .rsp_swipe              (rsp_swipe),
      .rsp_swipe_toward_higher(rsp_swipe_toward_higher),
      .rsp_center_column      (rsp_center_column),
      .rsp_peak_level         (rsp_peak_level),
      .rsp_motion_active      (rsp_motion_active),
      .rsp_reference_only     (rsp_reference_only)
   );

endmodule

>>> rtl/msd_checker.sv
// Port-level checks of the motion swipe detector, bound to the top level.
module msd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic        rsp_swipe,
   input logic        rsp_swipe_toward_higher,
   input logic [10:0] rsp_center_column,
   input logic [7:0]  rsp_peak_level,
   input logic        rsp_motion_active,
   input logic        rsp_reference_only
);

   // No result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result visible after reset");

   // Hold a waiting result until it is popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_center_column)
         && $stable(rsp_peak_level) && $stable(rsp_swipe)
         && $stable(rsp_reference_only)))
      else $error("waiting result changed");

   a_ref_clear: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_reference_only) |-> (!rsp_swipe && !rsp_swipe_toward_higher
         && rsp_center_column == 11'd0 && rsp_peak_level == 8'd0 && !rsp_motion_active))
      else $error("reference result carries analysis");

   a_swipe_active: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_swipe) |-> rsp_motion_active)
      else $error("swipe without motion");

   a_idle_centre: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_motion_active) |-> (rsp_center_column == 11'd0
         && !rsp_swipe_toward_higher))
      else $error("inactive frame reports a centre");

endmodule

bind motion_swipe_detector msd_checker u_checker (.*);

>>> bench/tb_top.sv
// Testbench for the motion swipe detector: class-based scoreboard with task-driven stimulus.
`timescale 1ns / 1ps

module tb_top;
   import msd_pkg::*;

   localparam int MAXW = 1024;
   localparam int MAXH = 512;
   // column drain, divider and centre search of one frame, with margin
   localparam int SETTLE_CYCLES = 16 * 1024 + 256;
   localparam int HOLD_CYCLES = 40000;

   typedef struct packed {
      logic        swipe;
      logic        higher;
      logic [10:0] center;
      logic [7:0]  peak;
      logic        active;
      logic        ref_only;
   } frame_result_type;

   class swipe_scoreboard;
      bit [7:0] prev_pix [MAXW * MAXH];
      bit seen [MAXW * MAXH];
      int unsigned col_sum [MAXW];
      int unsigned col_pos, row_pos, last_center, run_cnt;
      bit have_prev;
      logic [1:0] last_dir;
      logic [10:0] width_reg;
      logic [9:0] height_reg;
      logic [7:0] floor_reg, thresh_reg, run_len_reg;
      frame_result_type frame_q[$];
      int mismatches;

      function new();
         col_pos = 0; row_pos = 0; last_center = 0; run_cnt = 0;
         have_prev = 0; last_dir = DIR_NONE; mismatches = 0;
         width_reg = RST_FRAME_WIDTH; height_reg = RST_FRAME_HEIGHT;
         floor_reg = RST_NOISE_FLOOR; thresh_reg = RST_ACTIVITY_THRESHOLD;
         run_len_reg = RST_SWIPE_RUN_LENGTH;
         foreach (col_sum[i]) col_sum[i] = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [10:0] val);
         case (idx)
            CSR_FRAME_WIDTH:        width_reg = val;
            CSR_FRAME_HEIGHT:       height_reg = val[9:0];
            CSR_NOISE_FLOOR:        floor_reg = val[7:0];
            CSR_ACTIVITY_THRESHOLD: thresh_reg = val[7:0];
            CSR_SWIPE_RUN_LENGTH:   run_len_reg = val[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned eff_w();
         if (width_reg == 0) return 1;
         return (width_reg > MAXW) ? MAXW : width_reg;
      endfunction

      function int unsigned eff_h();
         if (height_reg == 0) return 1;
         return (height_reg > MAXH) ? MAXH : height_reg;
      endfunction

      // position the next pixel lands at, without changing state
      function void place(bit fs, output int unsigned c, output int unsigned r);
         c = fs ? 0 : col_pos;
         r = fs ? 0 : row_pos;
         if (c >= eff_w()) begin
            c = 0;
            r++;
         end
         if (r >= eff_h()) begin
            c = 0;
            r = 0;
         end
      endfunction

      function bit addr_seen(bit fs);
         int unsigned c, r;
         place(fs, c, r);
         return seen[r * MAXW + c];
      endfunction

      function int unsigned level(int unsigned sum, int unsigned h);
         int unsigned q, rem;
         q = sum / h;
         rem = sum % h;
         if (2 * rem > h || (2 * rem == h && q[0])) q++;
         if (q > LEVEL_MAX) q = LEVEL_MAX;
         return (q > floor_reg) ? q - floor_reg : 0;
      endfunction

      function void note_pixel(bit [7:0] pix, bit fs);
         int unsigned c, r, a, w, h, v, total, peak, center, half, cum;
         bit active, higher, swipe;
         logic [1:0] dir;
         frame_result_type res;
         w = eff_w();
         h = eff_h();
         place(fs, c, r);
         if (c == 0 && r == 0) foreach (col_sum[i]) col_sum[i] = 0;
         a = r * MAXW + c;
         col_sum[c] += (pix > prev_pix[a]) ? pix - prev_pix[a] : prev_pix[a] - pix;
         prev_pix[a] = pix;
         seen[a] = 1;
         col_pos = c + 1;
         row_pos = r;
         if (c + 1 < w) return;
         col_pos = 0;
         row_pos = r + 1;
         if (r + 1 < h) return;
         row_pos = 0;
         res = '0;
         if (!have_prev) begin
            have_prev = 1;
            run_cnt = 0;
            res.ref_only = 1'b1;
            frame_q.push_back(res);
            return;
         end
         total = 0; peak = 0; center = 0; higher = 0; swipe = 0;
         for (int i = 0; i < w; i++) begin
            v = level(col_sum[i], h);
            total += v;
            if (v > peak) peak = v;
         end
         active = peak > thresh_reg;
         if (active) begin
            half = total / 2;
            cum = 0;
            while (center < w) begin
               cum += level(col_sum[center], h);
               if (cum >= half) break;
               center++;
            end
            higher = last_center < center;
            dir = higher ? DIR_HIGHER : DIR_LOWER;
            if (dir == last_dir) begin
               if (run_cnt < RUN_MAX) run_cnt++;
            end else begin
               run_cnt = 0;
               last_dir = dir;
            end
            swipe = run_cnt == run_len_reg;
         end else begin
            run_cnt = 0;
         end
         last_center = center;
         res.swipe = swipe;
         res.higher = higher;
         res.center = center[10:0];
         res.peak = peak[7:0];
         res.active = active;
         frame_q.push_back(res);
      endfunction

      function void cmp(string field, int unsigned want, int unsigned got);
         if (want == got) return;
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s expected %0d got %0d", $realtime, field, want, got);
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         if (frame_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t: unexpected result %p", $realtime, got);
            return;
         end
         want = frame_q.pop_front();
         cmp("swipe", want.swipe, got.swipe);
         cmp("swipe_toward_higher", want.higher, got.higher);
         cmp("center_column", want.center, got.center);
         cmp("peak_level", want.peak, got.peak);
         cmp("motion_active", want.active, got.active);
         cmp("reference_only", want.ref_only, got.ref_only);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_pixel = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_swipe, rsp_swipe_toward_higher, rsp_motion_active, rsp_reference_only;
   logic [10:0] rsp_center_column;
   logic [7:0]  rsp_peak_level;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_FRAME_WIDTH;
   logic [10:0] csr_wdata = '0;

   swipe_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   int recv_hold = 0;
   bit priming = 1'b1;

   motion_swipe_detector dut (.*);

   always #10 clock = ~clock;

   initial begin
      #200_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: check on accepted transaction, choose pop at falling edge
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_result({rsp_swipe, rsp_swipe_toward_higher, rsp_center_column,
                             rsp_peak_level, rsp_motion_active, rsp_reference_only});
         @(negedge clock);
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_idle);
         end
      end
   end

   task automatic push_pixel(bit [7:0] pix, bit fs);
      // never read a stored pixel that was not written
      if (!priming && !sb.addr_seen(fs)) fs = 1'b1;
      while ($urandom_range(0, 99) < send_idle) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_pixel <= pix;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_pixel(pix, fs);
   endtask

   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (sb.frame_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [10:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(int w, int h, int nf, int thr, int run);
      settle();
      write_csr(CSR_FRAME_WIDTH, 11'(w));
      write_csr(CSR_FRAME_HEIGHT, 11'(h));
      write_csr(CSR_NOISE_FLOOR, 11'(nf));
      write_csr(CSR_ACTIVITY_THRESHOLD, 11'(thr));
      write_csr(CSR_SWIPE_RUN_LENGTH, 11'(run));
   endtask

   // frames with a bright bar stepping one column per frame over a dim background
   task automatic bar_frames(int n, bit up);
      int unsigned w, h, k;
      bit [7:0] v;
      bit fs;
      w = sb.eff_w();
      h = sb.eff_h();
      k = $urandom_range(0, w - 1);
      for (int f = 0; f < n; f++) begin
         for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
               v = (c == k) ? 8'($urandom_range(180, 255)) : 8'($urandom_range(0, 12));
               if ($urandom_range(0, 99) < 3) v = 8'($urandom);
               fs = (r == 0 && c == 0) ? 1'($urandom_range(0, 1))
                                       : ($urandom_range(0, 199) == 0);
               push_pixel(v, fs);
            end
         end
         k = up ? (k + 1) % w : (k + w - 1) % w;
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reference frame over every position the later geometries reach
      configure(10, 3, 10, 20, 4);
      for (int i = 0; i < 30; i++) push_pixel(8'($urandom), i == 0);
      priming = 1'b0;

      // directed: single-pixel frames, zero run length, extremes of pixel
      configure(0, 0, 0, 0, 0);
      push_pixel(8'd255, 1'b1);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd0, 1'b1);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd128, 1'b1);
      push_pixel(8'd1, 1'b0);
      configure(1, 1, 255, 255, 254);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      configure(1, 1, 0, 255, 1);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      // rounding ties on two-line frames
      configure(3, 2, 0, 1, 1);
      bar_frames(3, 1'b1);

      for (int p = 0; p < 9; p++) begin
         configure($urandom_range(2, 5), $urandom_range(1, 2), $urandom_range(0, 8),
                   $urandom_range(0, 20), $urandom_range(1, 3));
         send_idle = (p < 3) ? 10 : (p < 6) ? 62 : 0;
         recv_idle = (p < 3) ? 62 : (p < 6) ? 10 : 0;
         bar_frames(3, 1'($urandom_range(0, 1)));
      end

      // one column, one line: every pixel ends a frame; drive the run count
      // into saturation while the receiver holds off and the block fills
      configure(1, 1, 0, 0, 255);
      send_idle = 0;
      recv_idle = 0;
      recv_hold = HOLD_CYCLES;
      for (int i = 0; i < 270; i++)
         push_pixel(i[0] ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 127)),
                    1'b0);

      settle();
      if (sb.mismatches == 0 && sb.frame_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
